// ===== hw/rtl/swg_pkg.sv =====
package swg_pkg;

   // Element format: signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS.
   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 10;

   // Sigmoid values are unsigned Q1.15.
   localparam int SIG_W    = 16;
   localparam int SIG_FRAC = 15;

   // The table spans 16 units of gate value, from -8 up to 8.
   localparam int TABLE_SPAN_LOG2 = 4;

   localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

   localparam logic signed [63:0] DATA_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] DATA_MIN = -(64'sd1 <<< (DATA_WIDTH - 1));

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic [SIG_W-1:0] sig_type;

   typedef struct packed {
      data_type val;
      logic     sat;
   } sat_type;

   // Round to nearest with ties away from zero, then shift right by sh.
   function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int sh);
      logic signed [63:0] half;
      logic signed [63:0] adj;
      logic signed [63:0] sum;
      half = 64'sd1 <<< (sh - 1);
      if (v[63]) begin
         adj = half - 64'sd1;
      end else begin
         adj = half;
      end
      sum = v + adj;
      return sum >>> sh;
   endfunction

   // Rounded product scaled back to the element format, clamped to the data range.
   function automatic sat_type sat_round(input logic signed [63:0] v);
      logic signed [63:0] r;
      sat_type res;
      r = rnd_shift(v, FRAC_BITS);
      if (r > DATA_MAX) begin
         res.val = DATA_WIDTH'(DATA_MAX);
         res.sat = 1'b1;
      end else if (r < DATA_MIN) begin
         res.val = DATA_WIDTH'(DATA_MIN);
         res.sat = 1'b1;
      end else begin
         res.val = DATA_WIDTH'(r);
         res.sat = 1'b0;
      end
      return res;
   endfunction

   // The functions below only build the sigmoid table during elaboration.

   // (a*b) >> 62 truncated to 64 bits.
   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   // Restoring division, quotient in the upper half and remainder in the lower.
   function automatic logic [127:0] udiv(input logic [63:0] n, input logic [63:0] dd);
      logic [64:0] r;
      logic [63:0] q;
      r = '0;
      q = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], n[b]};
         if (r >= {1'b0, dd}) begin
            r    = r - {1'b0, dd};
            q[b] = 1'b1;
         end
      end
      return {q, r[63:0]};
   endfunction

   // Entry i of a table with the given number of entries: round(32768*sigmoid(x)),
   // x = (i - entries/2)*16/entries, all in exact integer arithmetic.
   function automatic sig_type sig_entry(input int entries, input int i);
      logic [63:0]  pw [13];
      logic [63:0]  term;
      logic [63:0]  sp;
      logic [63:0]  sn;
      logic [63:0]  dv;
      logic [63:0]  e;
      logic [63:0]  d;
      logic [63:0]  q;
      logic [63:0]  v;
      logic [127:0] qr;
      logic [127:0] fr;
      int           half;
      int           k;
      term = Q62_ONE;
      sp   = Q62_ONE;
      sn   = '0;
      // Series for exp(-16/entries) in Q2.62.
      for (int n = 1; n < 64; n++) begin
         dv   = 64'(entries) * 64'(n);
         qr   = udiv(term, dv);
         fr   = udiv(qr[63:0] << 4, dv);
         term = (qr[127:64] << 4) + fr[127:64];
         if (n[0]) begin
            sn = sn + term;
         end else begin
            sp = sp + term;
         end
      end
      pw[0] = sp - sn;
      for (int b = 1; b < 13; b++) begin
         pw[b] = mul_q62(pw[b-1], pw[b-1]);
      end
      half = entries >> 1;
      if (i >= half) begin
         k = i - half;
      end else begin
         k = half - i;
      end
      e = Q62_ONE;
      for (int b = 0; b < 13; b++) begin
         if (((k >> b) & 1) != 0) begin
            e = mul_q62(e, pw[b]);
         end
      end
      d  = (Q62_ONE + e) >> 16;
      qr = udiv(Q62_ONE, d);
      q  = qr[127:64];
      v  = (q + 64'd1) >> 1;
      if (i >= half) begin
         return v[SIG_W-1:0];
      end else begin
         return SIG_W'(64'd32768 - v);
      end
   endfunction

endpackage

// ===== hw/rtl/swg_req_if.sv =====
interface swg_req_if;
   import swg_pkg::*;

   logic     valid;
   logic     ready;
   data_type gate_in;
   data_type up_in;
   data_type grad_in;

   modport source(output valid, output gate_in, output up_in, output grad_in,
                  input ready);
   modport sink(input valid, input gate_in, input up_in, input grad_in,
                output ready);
endinterface

// ===== hw/rtl/swg_rsp_if.sv =====
interface swg_rsp_if;
   import swg_pkg::*;

   logic     valid;
   logic     ready;
   data_type act_out;
   data_type grad_up_out;
   data_type gate_grad_out;
   logic     sat_flag;

   modport source(output valid, output act_out, output grad_up_out,
                  output gate_grad_out, output sat_flag, input ready);
   modport sink(input valid, input act_out, input grad_up_out,
                input gate_grad_out, input sat_flag, output ready);
endinterface

// ===== hw/rtl/swiglu_forward_backward_unit.sv =====
// Channel   Role     Handshake       Payload
// req_ch    sink     valid / ready   gate_in, up_in, grad_in (signed Q6.10)
// rsp_ch    source   valid / ready   act_out, grad_up_out, gate_grad_out, sat_flag
//
// An item moves through the stage registers into the output register, where its result
// can be taken; one item enters per cycle while the output is not stalled.
// The pipeline has eight register stages: table index, sigmoid table read,
// two rounds of products each followed by their roundings, the final gradient product
// and its saturation.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage moves on when it is empty or when the stage after it moves on, so a
// stalled result holds its stage while bubbles further up still fill.

module swiglu_forward_backward_unit #(
   parameter int SIG_TABLE_ENTRIES = 1024
) (
   input logic       clock,
   input logic       reset,
   swg_req_if.sink   req_ch,
   swg_rsp_if.source rsp_ch
);
   import swg_pkg::*;

   localparam int NUM_STAGES = 8;
   localparam int IDX_W      = $clog2(SIG_TABLE_ENTRIES);
   localparam int OFF_W      = FRAC_BITS + TABLE_SPAN_LOG2;
   localparam int OFF_SUM_W  = DATA_WIDTH + 2;
   localparam int OFF_BIAS   = 8 << FRAC_BITS;
   localparam int OFF_MAX    = (1 << OFF_W) - 1;
   localparam int PR_W       = 2 * DATA_WIDTH;              // dy*u
   localparam int P_W        = 2 * DATA_WIDTH - FRAC_BITS;  // rounded dy*u
   localparam int GS_W       = DATA_WIDTH + SIG_W + 1;      // g*s and g*(1-s)
   localparam int H_W        = DATA_WIDTH + 1;              // silu and t
   localparam int TS_W       = DATA_WIDTH + 2;              // 1 + t
   localparam int DP_W       = SIG_W + 1 + TS_W;            // s*(1 + t)
   localparam int DS_W       = DATA_WIDTH + 2;              // dsilu
   localparam int AP_W       = H_W + DATA_WIDTH;            // silu*u and dy*silu
   localparam int GP_W       = P_W + DS_W;                  // p*dsilu

   localparam logic [IDX_W:0]   ENTRIES_L = (IDX_W + 1)'(SIG_TABLE_ENTRIES);
   localparam logic [SIG_W:0]   ONE_Q15   = (SIG_W + 1)'(1 << SIG_FRAC);
   localparam logic signed [TS_W-1:0] ONE_QF = TS_W'(1 << FRAC_BITS);

   // Sigmoid table, filled with constants during elaboration.
   sig_type sig_rom [SIG_TABLE_ENTRIES];

   for (genvar gi = 0; gi < SIG_TABLE_ENTRIES; gi++) begin : g_rom
      localparam sig_type ROM_VAL = sig_entry(SIG_TABLE_ENTRIES, gi);
      assign sig_rom[gi] = ROM_VAL;
   end

   // Stage control.
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] en;

   always_comb begin
      en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ch.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   assign vld_in = {vld_ff[NUM_STAGES-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_ch.ready = en[0];
   assign rsp_ch.valid = vld_ff[NUM_STAGES-1];

   // Stage 1: clamp the gate to the table range and form the table index.
   logic signed [OFF_SUM_W-1:0] off_sum;
   logic [OFF_W-1:0]            off_clamp;
   logic [OFF_W+IDX_W:0]        idx_prod;
   logic [IDX_W-1:0]            idx1_in;

   always_comb begin
      off_sum = OFF_SUM_W'(req_ch.gate_in) + OFF_SUM_W'(OFF_BIAS);
      if (off_sum < 0) begin
         off_clamp = '0;
      end else if (off_sum > OFF_SUM_W'(OFF_MAX)) begin
         off_clamp = OFF_W'(OFF_MAX);
      end else begin
         off_clamp = off_sum[OFF_W-1:0];
      end
      idx_prod = {{(IDX_W + 1){1'b0}}, off_clamp} * {{OFF_W{1'b0}}, ENTRIES_L};
      idx1_in  = idx_prod[OFF_W +: IDX_W];
   end

   data_type         g1_ff, u1_ff, dy1_ff;
   logic [IDX_W-1:0] idx1_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         g1_ff   <= req_ch.gate_in;
         u1_ff   <= req_ch.up_in;
         dy1_ff  <= req_ch.grad_in;
         idx1_ff <= idx1_in;
      end
   end

   // Stage 2: table read and dy*u.
   sig_type                 s2_ff;
   logic signed [PR_W-1:0]  pr2_ff, pr2_in;
   data_type                g2_ff, u2_ff, dy2_ff;

   assign pr2_in = PR_W'(dy1_ff) * PR_W'(u1_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_ff  <= sig_rom[idx1_ff];
         pr2_ff <= pr2_in;
         g2_ff  <= g1_ff;
         u2_ff  <= u1_ff;
         dy2_ff <= dy1_ff;
      end
   end

   // Stage 3: g*s, g*(1-s) and the rounded dy*u.
   logic [SIG_W:0]          cs2;
   logic signed [GS_W-1:0]  gs3_in, gt3_in, gs3_ff, gt3_ff;
   logic signed [P_W-1:0]   p3_in, p3_ff;
   sig_type                 s3_ff;
   data_type                u3_ff, dy3_ff;

   always_comb begin
      cs2    = ONE_Q15 - {1'b0, s2_ff};
      gs3_in = GS_W'(g2_ff) * GS_W'(signed'({1'b0, s2_ff}));
      gt3_in = GS_W'(g2_ff) * GS_W'(signed'(cs2));
      p3_in  = P_W'(rnd_shift(64'(pr2_ff), FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         gs3_ff <= gs3_in;
         gt3_ff <= gt3_in;
         p3_ff  <= p3_in;
         s3_ff  <= s2_ff;
         u3_ff  <= u2_ff;
         dy3_ff <= dy2_ff;
      end
   end

   // Stage 4: silu = rnd(g*s) and 1 + t with t = rnd(g*(1-s)).
   logic signed [H_W-1:0]  silu4_in, silu4_ff, t4;
   logic signed [TS_W-1:0] ts4_in, ts4_ff;
   logic signed [P_W-1:0]  p4_ff;
   sig_type                s4_ff;
   data_type               u4_ff, dy4_ff;

   always_comb begin
      silu4_in = H_W'(rnd_shift(64'(gs3_ff), SIG_FRAC));
      t4       = H_W'(rnd_shift(64'(gt3_ff), SIG_FRAC));
      ts4_in   = ONE_QF + TS_W'(t4);
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         silu4_ff <= silu4_in;
         ts4_ff   <= ts4_in;
         p4_ff    <= p3_ff;
         s4_ff    <= s3_ff;
         u4_ff    <= u3_ff;
         dy4_ff   <= dy3_ff;
      end
   end

   // Stage 5: s*(1+t), silu*u and dy*silu.
   logic signed [DP_W-1:0] dp5_in, dp5_ff;
   logic signed [AP_W-1:0] ap5_in, ap5_ff, gp5_in, gp5_ff;
   logic signed [P_W-1:0]  p5_ff;

   always_comb begin
      dp5_in = DP_W'(signed'({1'b0, s4_ff})) * DP_W'(ts4_ff);
      ap5_in = AP_W'(silu4_ff) * AP_W'(u4_ff);
      gp5_in = AP_W'(dy4_ff) * AP_W'(silu4_ff);
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         dp5_ff <= dp5_in;
         ap5_ff <= ap5_in;
         gp5_ff <= gp5_in;
         p5_ff  <= p4_ff;
      end
   end

   // Stage 6: dsilu rounding, forward result and grad_up saturation.
   logic signed [DS_W-1:0] ds6_in, ds6_ff;
   sat_type                act6_in, gu6_in, act6_ff, gu6_ff;
   logic signed [P_W-1:0]  p6_ff;

   always_comb begin
      ds6_in  = DS_W'(rnd_shift(64'(dp5_ff), SIG_FRAC));
      act6_in = sat_round(64'(ap5_ff));
      gu6_in  = sat_round(64'(gp5_ff));
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         ds6_ff  <= ds6_in;
         act6_ff <= act6_in;
         gu6_ff  <= gu6_in;
         p6_ff   <= p5_ff;
      end
   end

   // Stage 7: p*dsilu.
   logic signed [GP_W-1:0] gg7_in, gg7_ff;
   data_type               act7_ff, gu7_ff;
   logic                   sat7_ff;

   assign gg7_in = GP_W'(p6_ff) * GP_W'(ds6_ff);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         gg7_ff  <= gg7_in;
         act7_ff <= act6_ff.val;
         gu7_ff  <= gu6_ff.val;
         sat7_ff <= act6_ff.sat | gu6_ff.sat;
      end
   end

   // Stage 8: gate gradient saturation; this is the output register.
   sat_type  gg8_in;
   data_type act8_ff, gu8_ff, gg8_ff;
   logic     sat8_ff;

   assign gg8_in = sat_round(64'(gg7_ff));

   always_ff @(posedge clock) begin
      if (en[7]) begin
         act8_ff <= act7_ff;
         gu8_ff  <= gu7_ff;
         gg8_ff  <= gg8_in.val;
         sat8_ff <= sat7_ff | gg8_in.sat;
      end
   end

   assign rsp_ch.act_out       = act8_ff;
   assign rsp_ch.grad_up_out   = gu8_ff;
   assign rsp_ch.gate_grad_out = gg8_ff;
   assign rsp_ch.sat_flag      = sat8_ff;

endmodule
